### hdl/hbsne_pkg.sv
// hbsne_pkg: shared constants, types and state encodings for the novelty engine.
// No dependencies; compile first.

package hbsne_pkg;

  // Store geometry. STORE_BYTES must be a power of two (address taken as a bit field).
  localparam int STORE_BYTES = 1024;
  localparam int PROBES      = 128;

  localparam int ADDR_W  = $clog2(STORE_BYTES);
  localparam int PIDX_W  = $clog2(PROBES + 1);
  localparam int NOV_W   = $clog2(PROBES + 1);
  // signed compare width: holds novelty and threshold +/- adjust (-127..382)
  localparam int CMP_W   = ((NOV_W > 9) ? NOV_W : 9) + 2;

  localparam logic [31:0] DJB2_INIT = 32'd5381;

  localparam int          LCG_W    = 31;
  localparam logic [30:0] LCG_MUL  = 31'd1103515245;
  localparam logic [30:0] LCG_ADD  = 31'd12345;
  localparam int          ADDR_LSB = 16;
  localparam int          BIT_LSB  = 8;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOLD_TH    = 3'd0,
    CFG_SPIKE_TH   = 3'd1,
    CFG_MODE_ADJ   = 3'd2,
    CFG_STEP_UP    = 3'd3,
    CFG_STEP_DOWN  = 3'd4,
    CFG_HIGH_LEVEL = 3'd5,
    CFG_LOW_LEVEL  = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_CALM     = 2'd0,
    MODE_BALANCED = 2'd1,
    MODE_CHAOTIC  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [7:0]  fold_th;
    logic [7:0]  spike_th;
    logic [6:0]  mode_adj;
    logic [7:0]  step_up;
    logic [7:0]  step_down;
    logic [15:0] high_level;
    logic [15:0] low_level;
  } cfg_t;

  // control -> probe walker
  typedef struct packed {
    logic        start;
    logic        toggle;
    logic [31:0] seed;
  } walk_cmd_t;

  // probe walker -> control
  typedef struct packed {
    logic             ready;
    logic             done;
    logic [NOV_W-1:0] zeros;
  } walk_stat_t;

  typedef enum logic [2:0] {
    W_CLEAR,
    W_IDLE,
    W_SEED,
    W_RD,
    W_ACT
  } walk_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WALK,
    S_LEVEL,
    S_FOLD,
    S_FWALK,
    S_DONE
  } ctl_state_t;

endpackage

### hdl/hbsne_in_if.sv
// hbsne_in_if: text byte channel (valid/ready plus byte payload).
// No dependencies.

interface hbsne_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] char_byte;
  logic       last;

  modport source (output valid, func, char_byte, last, input ready);
  modport sink   (input valid, func, char_byte, last, output ready);
endinterface

### hdl/hbsne_out_if.sv
// hbsne_out_if: result channel (valid/ready plus result payload).
// No dependencies.

interface hbsne_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] mixed_hash;
  logic [7:0]  novelty;
  logic        folded;
  logic        spike;
  logic [1:0]  mode;
  logic [15:0] level;

  modport source (output valid, mixed_hash, novelty, folded, spike, mode, level, input ready);
  modport sink   (input valid, mixed_hash, novelty, folded, spike, mode, level, output ready);
endinterface

### hdl/hbsne_ram.sv
// hbsne_ram: simple dual-port RAM, one write and one read port, registered read.
// No dependencies.

module hbsne_ram #(
  parameter  int DEPTH = 1024,
  parameter  int WIDTH = 8,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/hbsne_walker.sv
// hbsne_walker: LCG probe walker over the bit store; counts zero bits or toggles them.
// Also runs the clearing pass after reset. Depends on hbsne_pkg, hbsne_ram.

module hbsne_walker
  import hbsne_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  walk_cmd_t  cmd,
  output walk_stat_t stat
);

  walk_state_t state, state_next;

  logic [LCG_W-1:0]  x;
  logic [LCG_W-1:0]  x_lcg;
  logic              toggle;
  logic [PIDX_W-1:0] pidx;
  logic [NOV_W-1:0]  zeros;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] addr_q;
  logic [2:0]        bit_q;
  logic              last_probe;
  logic              probe_bit;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  // 31-bit LCG step; product truncates to the masked width
  assign x_lcg      = x * LCG_MUL + LCG_ADD;
  assign last_probe = (pidx == PIDX_W'(PROBES - 1));
  assign probe_bit  = ram_rdata[bit_q];

  hbsne_ram #(
    .DEPTH(STORE_BYTES),
    .WIDTH(8)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      W_CLEAR: begin
        if (clr_addr == ADDR_W'(STORE_BYTES - 1)) state_next = W_IDLE;
      end
      W_IDLE: begin
        if (cmd.start) state_next = W_SEED;
      end
      W_SEED:  state_next = W_RD;
      W_RD:    state_next = W_ACT;
      W_ACT: begin
        state_next = last_probe ? W_IDLE : W_RD;
      end
      default: state_next = W_CLEAR;
    endcase
  end

  // Read in W_RD, write back in W_ACT; the next read, in the W_RD that follows, comes after the write,
  // so back-to-back probes of one byte see the updated data.
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = addr_q;
    ram_wdata  = ram_rdata ^ (8'd1 << bit_q);
    ram_raddr  = x[ADDR_LSB +: ADDR_W];
    stat.ready = 1'b0;
    stat.done  = 1'b0;
    stat.zeros = zeros;
    unique case (state)
      W_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      W_IDLE: stat.ready = 1'b1;
      W_SEED, W_RD: ;
      W_ACT: begin
        ram_we    = toggle;
        stat.done = last_probe;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= W_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == W_CLEAR) clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      W_IDLE: begin
        if (cmd.start) begin
          x      <= cmd.seed[LCG_W-1:0];
          toggle <= cmd.toggle;
          pidx   <= '0;
          zeros  <= '0;
        end
      end
      W_SEED: x <= x_lcg;
      W_RD: begin
        addr_q <= x[ADDR_LSB +: ADDR_W];
        bit_q  <= x[BIT_LSB +: 3];
        x      <= x_lcg;
      end
      W_ACT: begin
        pidx <= pidx + 1'b1;
        if (!toggle && !probe_bit) zeros <= zeros + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

### hdl/hbsne_level.sv
// hbsne_level: saturating entropy level register and the derived three-way mode.
// Depends on hbsne_pkg.

module hbsne_level
  import hbsne_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             update,
  input  logic [NOV_W-1:0] novelty,
  input  cfg_t             cfg,
  output logic [15:0]      level,
  output mode_t            mode
);

  logic        rise;
  logic [16:0] up_sum;
  logic [15:0] level_next;

  assign rise   = CMP_W'(novelty) > CMP_W'(cfg.spike_th);
  assign up_sum = {1'b0, level} + 17'(cfg.step_up);

  always_comb begin
    if (rise) begin
      level_next = up_sum[16] ? 16'hffff : up_sum[15:0];
    end else if (level > 16'(cfg.step_down)) begin
      level_next = level - 16'(cfg.step_down);
    end else begin
      level_next = '0;
    end
  end

  always_comb begin
    if (level > cfg.high_level) begin
      mode = MODE_CHAOTIC;
    end else if (level > cfg.low_level) begin
      mode = MODE_BALANCED;
    end else begin
      mode = MODE_CALM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (update) begin
      level <= level_next;
    end
  end

endmodule

### hdl/hashed_bit_sketch_novelty_engine.sv
// hashed_bit_sketch_novelty_engine: top level; byte hashing, sequencing, config, result register.
// Depends on hbsne_pkg, hbsne_in_if, hbsne_out_if, hbsne_walker, hbsne_level.
//
// Usage:
//   text   : byte transactions (func, char_byte, last). Bytes without last are taken one
//            per cycle while idle and folded into a djb2 hash; a zero byte stops hashing until last.
//   report : one result transaction per last byte.
//   cfg_*  : register writes (cfg_we, cfg_index, cfg_data), taken any cycle, no read-back.
// Steps from the last byte to report.valid:
//   query, no fold     : probe walk counting zero bits, level update, result register
//   query, with fold   : count walk, level update, fold walk toggling the probed bits, result register
//   remove             : probe walk toggling the probed bits, result register
// A query folds when its zero count exceeds fold_th. Each probe is one store read and one
// write-back slot over a single RAM with registered read. text.ready is low from the last
// byte until the result is placed in the output register.
// Reset: config returns to defaults, hash to 5381, previous mix and entropy to zero, and the
// store is swept to zero, one byte a cycle over all STORE_BYTES (1024); text.ready stays
// low during the sweep. Config writes are accepted during it.
// Stall: a result waits in the output register while report.ready is low; new bytes are
// still taken, and only the next last byte's result holds until the register frees.

module hashed_bit_sketch_novelty_engine
  import hbsne_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  hbsne_in_if.sink             text,
  hbsne_out_if.source          report,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam cfg_t CFG_RESET = '{
    fold_th:    8'd40,
    spike_th:   8'd80,
    mode_adj:   7'd15,
    step_up:    8'd10,
    step_down:  8'd2,
    high_level: 16'd50,
    low_level:  16'd10
  };

  ctl_state_t state, state_next;
  cfg_t       cfg;

  // byte-level hashing state
  logic [31:0] running_hash;
  logic        terminated;
  logic [31:0] prev_mixed;
  logic [31:0] hash_acc;
  logic        hashing;
  logic        accept;

  // per-text transaction
  logic [31:0]      mixed_q;
  logic             func_q;
  logic [NOV_W-1:0] nov_q;
  logic             fold_q;
  logic             fold;

  walk_cmd_t   walk_cmd;
  walk_stat_t  walk_stat;
  logic        level_update;
  logic [15:0] level;
  mode_t       mode;

  logic              load_out;
  logic signed [CMP_W-1:0] limit;
  logic              spike;

  // result register
  logic        out_valid;
  logic [31:0] out_mixed_hash;
  logic [7:0]  out_nov_sat;
  logic        out_fold_flag;
  logic        out_spike;
  logic [1:0]  out_mode;
  logic [15:0] out_level;

  function automatic logic [7:0] sat_nov(input logic [NOV_W-1:0] n);
    if ((NOV_W + 8)'(n) > (NOV_W + 8)'(255)) return 8'hff;
    return 8'(n);
  endfunction

  hbsne_walker u_walker (
    .clk (clk),
    .rst (rst),
    .cmd (walk_cmd),
    .stat(walk_stat)
  );

  // level update in S_LEVEL takes the fresh count straight from the walker
  hbsne_level u_level (
    .clk    (clk),
    .rst    (rst),
    .update (level_update),
    .novelty(walk_stat.zeros),
    .cfg    (cfg),
    .level  (level),
    .mode   (mode)
  );

  // --- byte hashing: h*33 + byte ---
  assign accept   = text.valid && text.ready;
  assign hashing  = !terminated && (text.char_byte != 8'd0);
  assign hash_acc = hashing ? (running_hash << 5) + running_hash + 32'(text.char_byte)
                            : running_hash;

  // fold decision once the count is in (state S_LEVEL)
  assign fold = CMP_W'(walk_stat.zeros) > CMP_W'(cfg.fold_th);

  // spike limit uses the mode after the level update; may go negative
  always_comb begin
    limit = $signed(CMP_W'(cfg.spike_th));
    case (mode)
      MODE_CALM:    limit = limit + $signed(CMP_W'(cfg.mode_adj));
      MODE_CHAOTIC: limit = limit - $signed(CMP_W'(cfg.mode_adj));
      default:      ;
    endcase
  end
  assign spike = !func_q && ($signed(CMP_W'(nov_q)) > limit);

  // --- sequencer ---
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && text.last) state_next = S_START;
      end
      S_START: state_next = S_WALK;
      S_WALK: begin
        if (walk_stat.done) state_next = func_q ? S_DONE : S_LEVEL;
      end
      S_LEVEL: state_next = fold ? S_FOLD : S_DONE;
      S_FOLD:  state_next = S_FWALK;
      S_FWALK: begin
        if (walk_stat.done) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || report.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    text.ready      = 1'b0;
    walk_cmd.start  = 1'b0;
    walk_cmd.toggle = 1'b0;
    walk_cmd.seed   = mixed_q;
    level_update    = 1'b0;
    load_out        = 1'b0;
    unique case (state)
      S_IDLE:  text.ready = walk_stat.ready;
      S_START: begin
        walk_cmd.start  = 1'b1;
        walk_cmd.toggle = func_q;
      end
      S_LEVEL: level_update = 1'b1;
      S_FOLD: begin
        walk_cmd.start  = 1'b1;
        walk_cmd.toggle = 1'b1;
      end
      S_DONE:  load_out = !out_valid || report.ready;
      S_WALK, S_FWALK: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --- config registers; writes past the list are dropped ---
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FOLD_TH:    cfg.fold_th    <= cfg_data[7:0];
        CFG_SPIKE_TH:   cfg.spike_th   <= cfg_data[7:0];
        CFG_MODE_ADJ:   cfg.mode_adj   <= cfg_data[6:0];
        CFG_STEP_UP:    cfg.step_up    <= cfg_data[7:0];
        CFG_STEP_DOWN:  cfg.step_down  <= cfg_data[7:0];
        CFG_HIGH_LEVEL: cfg.high_level <= cfg_data;
        CFG_LOW_LEVEL:  cfg.low_level  <= cfg_data;
        default:        ;
      endcase
    end
  end

  // --- hash, terminator flag, previous mixed hash ---
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= DJB2_INIT;
      terminated   <= 1'b0;
      prev_mixed   <= '0;
    end else if (accept) begin
      if (text.last) begin
        running_hash <= DJB2_INIT;
        terminated   <= 1'b0;
        if (!text.func) prev_mixed <= hash_acc ^ (prev_mixed >> 1);
      end else begin
        running_hash <= hash_acc;
        if (!terminated && (text.char_byte == 8'd0)) terminated <= 1'b1;
      end
    end
  end

  // per-text payload; remove walks the raw hash
  always_ff @(posedge clk) begin
    if (accept && text.last) begin
      func_q  <= text.func;
      mixed_q <= text.func ? hash_acc : hash_acc ^ (prev_mixed >> 1);
    end
    if (state == S_LEVEL) begin
      nov_q  <= walk_stat.zeros;
      fold_q <= fold;
    end
  end

  // --- result register ---
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_mixed_hash <= mixed_q;
      out_nov_sat    <= func_q ? 8'd0 : sat_nov(nov_q);
      out_fold_flag  <= func_q || fold_q;
      out_spike      <= spike;
      out_mode       <= mode;
      out_level      <= level;
    end
  end

  assign report.valid      = out_valid;
  assign report.mixed_hash = out_mixed_hash;
  assign report.novelty    = out_nov_sat;
  assign report.folded     = out_fold_flag;
  assign report.spike      = out_spike;
  assign report.mode       = out_mode;
  assign report.level      = out_level;

endmodule

### hdl/hbsne_checker.sv
// hbsne_checker: port-level assertions for the novelty engine, bound to the top level.
// Depends on hbsne_pkg and hashed_bit_sketch_novelty_engine.

module hbsne_checker
  import hbsne_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        text_valid,
  input logic        text_ready,
  input logic        text_last,
  input logic        report_valid,
  input logic        report_ready,
  input logic [31:0] report_mixed_hash,
  input logic [7:0]  report_novelty
);

  localparam int NOV_MAX = (PROBES > 255) ? 255 : PROBES;

  // store sweep follows every reset, so no bytes are taken right after it
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !text_ready)
    else $error("text accepted during store clearing");

  // a last byte starts the probe walk; input must close
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    text_valid && text_ready && text_last |=> !text_ready)
    else $error("text ready right after last byte");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    report_valid && !report_ready |=> report_valid && $stable(report_mixed_hash))
    else $error("stalled result dropped or changed");

  a_novelty_range: assert property (@(posedge clk) disable iff (rst)
    report_valid |-> report_novelty <= 8'(NOV_MAX))
    else $error("novelty exceeds probe count");

endmodule

bind hashed_bit_sketch_novelty_engine hbsne_checker u_hbsne_checker (
  .clk              (clk),
  .rst              (rst),
  .text_valid       (text.valid),
  .text_ready       (text.ready),
  .text_last        (text.last),
  .report_valid     (report.valid),
  .report_ready     (report.ready),
  .report_mixed_hash(report.mixed_hash),
  .report_novelty   (report.novelty)
);

### tb/hashed_bit_sketch_novelty_engine_tb.sv
// Self-checking testbench for hashed_bit_sketch_novelty_engine: a directed table, then random texts
// over several register settings, checked against an in-bench predictor of hash, sketch and entropy.
// Depends on hbsne_pkg, hbsne_in_if, hbsne_out_if and the engine RTL.

module hashed_bit_sketch_novelty_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hbsne_pkg::*;

  // ---------------------------------------------------------------------------
  // Constants
  // ---------------------------------------------------------------------------
  localparam logic FUNC_QUERY  = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  localparam int CFG_BAD_INDEX = 7;     // past the last register, must be ignored

  localparam logic [31:0] TEXT_HASH_INIT = 32'd5381;
  localparam int          HASH_MULT      = 33;
  localparam logic [30:0] LCG_FACTOR     = 31'd1103515245;
  localparam logic [30:0] LCG_STEP       = 31'd12345;
  localparam int          PROBE_ADDR_LSB = 16;
  localparam int          PROBE_BIT_LSB  = 8;
  localparam int          LEVEL_MAX      = 65535;
  localparam int          NOVELTY_MAX    = 255;

  localparam int MAX_WAIT        = 17;             // sender gap / receiver stall, cycles
  localparam int BUSY_CYCLES     = 4 * PROBES + 8; // query with fold, plus margin
  localparam int WATCHDOG_CYCLES = 4000;           // covers the store sweep too

  typedef struct packed {
    logic [31:0] mixed_hash;
    logic [7:0]  novelty;
    logic        folded;
    logic        spike;
    logic [1:0]  mode;
    logic [15:0] level;
  } report_t;

  typedef struct packed {
    logic    fn;
    logic [7:0] chr;
    logic    lst;
    logic    typed;   // expected result written below instead of predicted
    report_t want;
  } text_row_t;

  localparam cfg_t RESET_CFG = '{8'd40, 8'd80, 7'd15, 8'd10, 8'd2, 16'd50, 16'd10};

  // Directed table. Only the first two rows carry a hand-computed result:
  // a one-byte query on the cleared store sees all 128 probes clear, and an
  // empty remove reports the bare seed.
  localparam int N_DIRECTED = 23;
  localparam text_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{FUNC_QUERY,  8'h41, 1'b1, 1'b1, '{32'd177638, 8'd128, 1'b1, 1'b1, MODE_CALM, 16'd10}},
    '{FUNC_REMOVE, 8'h00, 1'b1, 1'b1, '{32'd5381,   8'd0,   1'b1, 1'b0, MODE_CALM, 16'd10}},
    '{FUNC_QUERY,  8'hff, 1'b1, 1'b0, '0},
    '{FUNC_REMOVE, 8'h01, 1'b0, 1'b0, '0},  // func on a non-final byte is don't-care
    '{FUNC_QUERY,  8'h80, 1'b1, 1'b0, '0},
    '{FUNC_QUERY,  8'h78, 1'b0, 1'b0, '0},
    '{FUNC_REMOVE, 8'h00, 1'b0, 1'b0, '0},  // terminator mid-text
    '{FUNC_QUERY,  8'h79, 1'b0, 1'b0, '0},  // not hashed
    '{FUNC_QUERY,  8'h55, 1'b1, 1'b0, '0},  // not hashed either
    '{FUNC_REMOVE, 8'h72, 1'b0, 1'b0, '0},
    '{FUNC_REMOVE, 8'h6d, 1'b1, 1'b0, '0},
    '{FUNC_QUERY,  8'h00, 1'b1, 1'b0, '0},  // empty query
    '{FUNC_QUERY,  8'h00, 1'b0, 1'b0, '0},
    '{FUNC_QUERY,  8'hff, 1'b1, 1'b0, '0},
    '{FUNC_QUERY,  8'h61, 1'b0, 1'b0, '0},
    '{FUNC_QUERY,  8'h62, 1'b0, 1'b0, '0},
    '{FUNC_QUERY,  8'h63, 1'b1, 1'b0, '0},
    '{FUNC_QUERY,  8'h61, 1'b0, 1'b0, '0},  // same text removed
    '{FUNC_REMOVE, 8'h62, 1'b0, 1'b0, '0},
    '{FUNC_REMOVE, 8'h63, 1'b1, 1'b0, '0},
    '{FUNC_REMOVE, 8'h61, 1'b0, 1'b0, '0},  // and queried again
    '{FUNC_QUERY,  8'h62, 1'b0, 1'b0, '0},
    '{FUNC_QUERY,  8'h63, 1'b1, 1'b0, '0}
  };

  // Register phases. Fields: fold, spike, adjust, step up, step down, high, low.
  //   0 reset values written back explicitly
  //   1 never spikes, big step down: entropy clamps at zero
  //   2 fold whenever a probe reads clear, adjust 127: chaotic limit below zero, every chaotic query spikes
  //   3 never folds, step up 255: entropy saturates
  //   4 high level 0, step up 0
  //   5.. random settings
  localparam int N_FIXED  = 5;
  localparam int N_PHASES = 7;
  localparam cfg_t PHASE_CFG [N_FIXED] = '{
    '{8'd40,  8'd80,  7'd15,  8'd10,  8'd2,   16'd50,    16'd10},
    '{8'd100, 8'd255, 7'd0,   8'd0,   8'd255, 16'd65535, 16'd65535},
    '{8'd0,   8'd0,   7'd127, 8'd255, 8'd255, 16'd300,   16'd100},
    '{8'd128, 8'd0,   7'd0,   8'd255, 8'd0,   16'd65535, 16'd0},
    '{8'd64,  8'd255, 7'd127, 8'd0,   8'd255, 16'd0,     16'd0}
  };
  localparam int PHASE_TEXTS  [N_PHASES] = '{90, 30, 50, 300, 30, 30, 30};
  localparam int PHASE_MAXLEN [N_PHASES] = '{8, 6, 6, 2, 10, 12, 12};

  // ---------------------------------------------------------------------------
  // Clock, DUT
  // ---------------------------------------------------------------------------
  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  hbsne_in_if  text_ch ();
  hbsne_out_if report_ch ();

  hashed_bit_sketch_novelty_engine u_dut (
    .clk       (clk),
    .rst       (rst),
    .text      (text_ch.sink),
    .report    (report_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state
  // ---------------------------------------------------------------------------
  logic [31:0] hash_acc;
  bit          text_ended;
  logic [31:0] prev_mix;
  int          level_q;
  logic [7:0]  sketch_mem [STORE_BYTES];
  cfg_t        regs_q;

  report_t pending_reports [$];
  int      mismatches;
  int      idle_cycles;
  bit      quiet;   // no gaps, no stalls

  function automatic logic [30:0] next_lcg(input logic [30:0] x);
    return x * LCG_FACTOR + LCG_STEP;
  endfunction

  function automatic void flip_probed_bits(input logic [31:0] seed);
    logic [30:0] x;
    x = seed[30:0];
    for (int i = 0; i < PROBES; i++) begin
      x = next_lcg(x);
      sketch_mem[x[PROBE_ADDR_LSB +: ADDR_W]][x[PROBE_BIT_LSB +: 3]] =
        ~sketch_mem[x[PROBE_ADDR_LSB +: ADDR_W]][x[PROBE_BIT_LSB +: 3]];
    end
  endfunction

  // One accepted byte through the hash, and on a final byte the query or
  // remove against the sketch and the entropy tracker.
  task automatic predict_byte(input logic fn, input logic [7:0] chr, input logic lst,
                              output bit produced, output report_t r);
    logic [30:0] x;
    logic [31:0] raw;
    int          zeros;
    int          lim;
    mode_t       m;
    produced = 1'b0;
    r        = '0;
    zeros    = 0;
    if (!text_ended) begin
      if (chr == 8'h00) text_ended = 1'b1;
      else hash_acc = hash_acc * HASH_MULT + chr;
    end
    if (lst) begin
      raw        = hash_acc;
      hash_acc   = TEXT_HASH_INIT;
      text_ended = 1'b0;
      if (fn == FUNC_QUERY) begin
        r.mixed_hash = raw ^ (prev_mix >> 1);
        prev_mix     = r.mixed_hash;
        x = r.mixed_hash[30:0];
        for (int i = 0; i < PROBES; i++) begin
          x = next_lcg(x);
          if (!sketch_mem[x[PROBE_ADDR_LSB +: ADDR_W]][x[PROBE_BIT_LSB +: 3]])
            zeros = zeros + 1;
        end
        if (zeros > int'(regs_q.spike_th)) begin
          level_q = level_q + int'(regs_q.step_up);
          if (level_q > LEVEL_MAX) level_q = LEVEL_MAX;
        end else begin
          level_q = (level_q > int'(regs_q.step_down)) ? level_q - int'(regs_q.step_down) : 0;
        end
      end
      // mode after the update; a remove leaves the level alone
      if (level_q > int'(regs_q.high_level)) m = MODE_CHAOTIC;
      else if (level_q > int'(regs_q.low_level)) m = MODE_BALANCED;
      else m = MODE_CALM;
      if (fn == FUNC_REMOVE) begin
        flip_probed_bits(raw);
        r.mixed_hash = raw;
        r.folded     = 1'b1;
      end else begin
        if (zeros > int'(regs_q.fold_th)) begin
          flip_probed_bits(r.mixed_hash);
          r.folded = 1'b1;
        end
        // signed limit, may go negative in chaotic mode
        lim = int'(regs_q.spike_th);
        if (m == MODE_CALM) lim = lim + int'(regs_q.mode_adj);
        else if (m == MODE_CHAOTIC) lim = lim - int'(regs_q.mode_adj);
        r.spike   = (zeros > lim);
        r.novelty = (zeros > NOVELTY_MAX) ? 8'(NOVELTY_MAX) : 8'(zeros);
      end
      r.mode   = m;
      r.level  = level_q[15:0];
      produced = 1'b1;
    end
  endtask

  function automatic int draw_wait();
    if (quiet || $urandom_range(0, 9) < 3) return 0;
    return $urandom_range(1, MAX_WAIT);
  endfunction

  // ---------------------------------------------------------------------------
  // Text side
  // ---------------------------------------------------------------------------
  // Valid stays high when the next gap is zero; it is only lowered before a gap or in drain_results.
  task automatic send_byte(input logic fn, input logic [7:0] chr, input logic lst,
                           output bit produced, output report_t r);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_ch.valid     <= 1'b1;
    text_ch.func      <= fn;
    text_ch.char_byte <= chr;
    text_ch.last      <= lst;
    @(posedge clk);
    while (text_ch.ready !== 1'b1) @(posedge clk);
    predict_byte(fn, chr, lst, produced, r);
  endtask

  // Hold the text side until every expected result has been taken.
  task automatic drain_results();
    text_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stalls are applied while a result is waiting
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int      stall;
    report_t got;
    report_t want;
    report_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        report_ch.ready <= 1'b0;
        @(posedge clk);
        while (report_ch.valid !== 1'b1) @(posedge clk);
        repeat (stall - 1) @(posedge clk);
      end
      report_ch.ready <= 1'b1;
      @(posedge clk);
      while (report_ch.valid !== 1'b1) @(posedge clk);
      got = '{report_ch.mixed_hash, report_ch.novelty, report_ch.folded,
              report_ch.spike, report_ch.mode, report_ch.level};
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected report transaction, hash %h nov %0d", $time,
                   got.mixed_hash, got.novelty);
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: report mismatch: expected hash %h nov %0d fold %b spike %b ",
                     $time, want.mixed_hash, want.novelty, want.folded, want.spike,
                     "mode %0d level %0d; got hash %h nov %0d fold %b spike %b ",
                     want.mode, want.level, got.mixed_hash, got.novelty, got.folded,
                     got.spike, "mode %0d level %0d", got.mode, got.level);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: cycles with no transaction on either channel
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((text_ch.valid === 1'b1 && text_ch.ready === 1'b1) ||
          (report_ch.valid === 1'b1 && report_ch.ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
    end
    $display("hashed_bit_sketch_novelty_engine_tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    bit         produced;
    report_t    r;
    cfg_t       c;
    int         len;
    logic       fn;
    logic [7:0] chr;
    logic [CFG_W-1:0] d;

    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    text_ch.valid     <= 1'b0;
    text_ch.func      <= 1'b0;
    text_ch.char_byte <= 8'h00;
    text_ch.last      <= 1'b0;
    mismatches = 0;
    quiet      = 1'b0;
    hash_acc   = TEXT_HASH_INIT;
    text_ended = 1'b0;
    prev_mix   = '0;
    level_q    = 0;
    regs_q     = RESET_CFG;
    for (int i = 0; i < STORE_BYTES; i++) sketch_mem[i] = 8'h00;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed table under reset settings; text.ready holds off through the store sweep
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_byte(DIRECTED_ROWS[i].fn, DIRECTED_ROWS[i].chr, DIRECTED_ROWS[i].lst, produced, r);
      if (produced)
        pending_reports.push_back(DIRECTED_ROWS[i].typed ? DIRECTED_ROWS[i].want : r);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      // block idle before register writes: results in, then the longest busy stretch
      drain_results();
      repeat (BUSY_CYCLES) @(posedge clk);

      if (p < N_FIXED) begin
        c = PHASE_CFG[p];
      end else begin
        c.fold_th    = 8'($urandom_range(0, 128));
        c.spike_th   = 8'($urandom_range(0, 255));
        c.mode_adj   = 7'($urandom_range(0, 127));
        c.step_up    = 8'($urandom_range(0, 255));
        c.step_down  = 8'($urandom_range(0, 255));
        c.high_level = 16'($urandom_range(0, 600));
        c.low_level  = 16'($urandom_range(0, 300));
      end

      // back-to-back writes of every register, then one to the unused index
      cfg_we <= 1'b1;
      for (int i = 0; i <= CFG_BAD_INDEX; i++) begin
        case (i)
          CFG_FOLD_TH:    d = CFG_W'(c.fold_th);
          CFG_SPIKE_TH:   d = CFG_W'(c.spike_th);
          CFG_MODE_ADJ:   d = CFG_W'(c.mode_adj);
          CFG_STEP_UP:    d = CFG_W'(c.step_up);
          CFG_STEP_DOWN:  d = CFG_W'(c.step_down);
          CFG_HIGH_LEVEL: d = c.high_level;
          CFG_LOW_LEVEL:  d = c.low_level;
          default:        d = CFG_W'($urandom_range(0, 65535));
        endcase
        cfg_index <= CFG_IDX_W'(i);
        cfg_data  <= d;
        @(posedge clk);
      end
      cfg_we <= 1'b0;
      regs_q = c;

      quiet = (p % 3 == 2);

      // texts: mostly printable, some raw bytes and early terminators
      for (int t = 0; t < PHASE_TEXTS[p]; t++) begin
        len = $urandom_range(1, PHASE_MAXLEN[p]);
        for (int b = 0; b < len; b++) begin
          case ($urandom_range(0, 19))
            0:       chr = 8'h00;
            1, 2, 3: chr = 8'($urandom_range(0, 255));
            default: chr = 8'($urandom_range(32, 126));
          endcase
          if (b == len - 1)
            fn = ($urandom_range(0, 99) < 15) ? FUNC_REMOVE : FUNC_QUERY;
          else
            fn = 1'($urandom_range(0, 1));
          send_byte(fn, chr, b == len - 1, produced, r);
          if (produced) pending_reports.push_back(r);
        end
        if ($urandom_range(0, 39) == 0) drain_results();
      end
    end

    drain_results();
    repeat (BUSY_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_reports.size() == 0)
      $display("hashed_bit_sketch_novelty_engine_tb OK");
    else
      $display("hashed_bit_sketch_novelty_engine_tb NOT OK");
    $finish;
  end

endmodule

### files.f
hdl/hbsne_pkg.sv
hdl/hbsne_in_if.sv
hdl/hbsne_out_if.sv
hdl/hbsne_ram.sv
hdl/hbsne_walker.sv
hdl/hbsne_level.sv
hdl/hashed_bit_sketch_novelty_engine.sv
hdl/hbsne_checker.sv
tb/hashed_bit_sketch_novelty_engine_tb.sv
